// ===== design/hdlc_frame_decoder_macros.svh =====
// ---------------------------------------------------------------------------
// hdlc_frame_decoder_macros.svh
// Assertion macros used by the frame decoder back end (hfd_back).
// ---------------------------------------------------------------------------
`ifndef HDLC_FRAME_DECODER_MACROS_SVH
`define HDLC_FRAME_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// property checked outside reset
`define HFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define HFD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HFD_ASSERT(label, clk, rst, prop, msg)
`define HFD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== design/hfd_pkg.sv =====
// ---------------------------------------------------------------------------
// hfd_pkg
// Types, constants and the CRC-16/X.25 byte update for the frame decoder.
// ---------------------------------------------------------------------------
package hfd_pkg;

   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [7:0]  FLAG_RESET   = 8'h7E;
   localparam logic [7:0]  ESCAPE_RESET = 8'h7D;
   localparam logic [7:0]  MASK_RESET   = 8'h20;
   localparam logic [15:0] MAX_RESET    = 16'd1024;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      REG_FLAG   = 2'd0,
      REG_ESCAPE = 2'd1,
      REG_MASK   = 2'd2,
      REG_MAX    = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_OVERFLOW = 3'd2,
      ST_BAD_CRC  = 3'd3,
      ST_DANGLING = 3'd4
   } status_type;

   typedef enum logic {
      OP_DATA  = 1'b0,
      OP_CLOSE = 1'b1
   } op_type;

   typedef struct packed {
      logic [7:0]  flag_byte;
      logic [7:0]  escape_byte;
      logic [7:0]  escape_mask;
      logic [15:0] max_frame_bytes;
   } cfg_type;

   // one classified beat handed from front to back
   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       esc_pending;   // close only: escape was left open
   } item_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== design/hfd_front.sv =====
// ---------------------------------------------------------------------------
// hfd_front
// Accepts raw bytes, strips flags and escapes, queues data and close beats.
// ---------------------------------------------------------------------------
module hfd_front (
   input  logic              clock,
   input  logic              reset,
   input  hfd_pkg::cfg_type  cfg,
   input  logic              req_valid,
   input  logic [7:0]        req_in_byte,
   input  logic              q_full,
   output logic              push,
   output hfd_pkg::item_type push_item
);

   logic esc_ff, esc_in;
   logic seen_ff, seen_in;   // a raw byte arrived since the last flag
   logic accept;

   assign accept = req_valid && !q_full;

   always_comb begin
      esc_in            = esc_ff;
      seen_in           = seen_ff;
      push              = 1'b0;
      push_item.op      = hfd_pkg::OP_DATA;
      push_item.data    = req_in_byte;
      push_item.esc_pending = esc_ff;
      if (accept) begin
         if (req_in_byte == cfg.flag_byte) begin
            push         = seen_ff;   // empty frames vanish here
            push_item.op = hfd_pkg::OP_CLOSE;
            esc_in       = 1'b0;
            seen_in      = 1'b0;
         end else begin
            seen_in = 1'b1;
            if (esc_ff) begin
               esc_in         = 1'b0;
               push           = 1'b1;
               push_item.data = req_in_byte ^ cfg.escape_mask;
            end else if (req_in_byte == cfg.escape_byte) begin
               esc_in = 1'b1;
            end else begin
               push = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff  <= 1'b0;
         seen_ff <= 1'b0;
      end else begin
         esc_ff  <= esc_in;
         seen_ff <= seen_in;
      end
   end

endmodule

// ===== design/hfd_queue.sv =====
// ---------------------------------------------------------------------------
// hfd_queue
// Two-entry queue of classified beats between front and back.
// ---------------------------------------------------------------------------
module hfd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hfd_pkg::item_type push_item,
   input  logic              pop,
   output logic              q_valid,
   output logic              q_full,
   output hfd_pkg::item_type head
);

   hfd_pkg::item_type                  mem_ff [hfd_pkg::QUEUE_DEPTH];
   logic [hfd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hfd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [hfd_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   localparam logic [hfd_pkg::QPTR_W-1:0] LAST = hfd_pkg::QPTR_W'(hfd_pkg::QUEUE_DEPTH - 1);
   localparam logic [hfd_pkg::QCNT_W-1:0] FULL = hfd_pkg::QCNT_W'(hfd_pkg::QUEUE_DEPTH);

   assign q_valid = (cnt_ff != '0);
   assign q_full  = (cnt_ff == FULL);
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/hfd_back.sv =====
// ---------------------------------------------------------------------------
// hfd_back
// Runs the two-byte tail, CRC, length and overflow; drives the result beat.
// ---------------------------------------------------------------------------
`include "hdlc_frame_decoder_macros.svh"

module hfd_back (
   input  logic              clock,
   input  logic              reset,
   input  hfd_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  hfd_pkg::item_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_data_valid,
   output logic              rsp_frame_end,
   output logic [2:0]        rsp_frame_status,
   output logic [15:0]       rsp_payload_length
);

   logic [15:0] crc_ff, crc_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [7:0]  tail0_ff, tail0_in;
   logic [7:0]  tail1_ff, tail1_in;
   logic        ovf_ff, ovf_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_dv_ff, rsp_dv_in;
   logic        rsp_end_ff, rsp_end_in;
   hfd_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_len_ff, rsp_len_in;

   logic        advance;
   logic        emit;
   logic [15:0] cnt_inc;
   logic [15:0] crc_calc;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = q_valid && advance;
   assign cnt_inc = cnt_ff + 16'd1;
   assign crc_calc = ~crc_ff;

   always_comb begin
      crc_in        = crc_ff;
      cnt_in        = cnt_ff;
      tail0_in      = tail0_ff;
      tail1_in      = tail1_ff;
      ovf_in        = ovf_ff;
      emit          = 1'b0;
      rsp_byte_in   = 8'h00;
      rsp_dv_in     = 1'b0;
      rsp_end_in    = 1'b0;
      rsp_status_in = hfd_pkg::ST_OK;
      rsp_len_in    = 16'd0;
      if (pop) begin
         if (head.op == hfd_pkg::OP_CLOSE) begin
            emit       = 1'b1;
            rsp_end_in = 1'b1;
            rsp_len_in = (cnt_ff >= 16'd2) ? cnt_ff - 16'd2 : 16'd0;
            if (ovf_ff) begin
               rsp_status_in = hfd_pkg::ST_OVERFLOW;
            end else if (cnt_ff < 16'd2) begin
               rsp_status_in = hfd_pkg::ST_SHORT;
            end else if (head.esc_pending) begin
               rsp_status_in = hfd_pkg::ST_DANGLING;
            end else if (crc_calc != {tail1_ff, tail0_ff}) begin
               rsp_status_in = hfd_pkg::ST_BAD_CRC;
            end
            crc_in   = hfd_pkg::CRC_INIT;
            cnt_in   = 16'd0;
            tail0_in = 8'h00;
            tail1_in = 8'h00;
            ovf_in   = 1'b0;
         end else if (!ovf_ff) begin
            if (cnt_ff >= 16'd2) begin
               // oldest tail byte leaves the delay line as payload
               emit        = 1'b1;
               rsp_dv_in   = 1'b1;
               rsp_byte_in = tail0_ff;
               crc_in      = hfd_pkg::crc_byte(crc_ff, tail0_ff);
            end
            tail0_in = tail1_ff;
            tail1_in = head.data;
            cnt_in   = cnt_inc;
            ovf_in   = (cnt_inc >= cfg.max_frame_bytes);
         end
      end
      rsp_valid_in = advance ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= hfd_pkg::CRC_INIT;
         cnt_ff       <= 16'd0;
         tail0_ff     <= 8'h00;
         tail1_ff     <= 8'h00;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         cnt_ff       <= cnt_in;
         tail0_ff     <= tail0_in;
         tail1_ff     <= tail1_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_dv_ff     <= rsp_dv_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_status_ff <= rsp_status_in;
         rsp_len_ff    <= rsp_len_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = rsp_byte_ff;
   assign rsp_data_valid     = rsp_dv_ff;
   assign rsp_frame_end      = rsp_end_ff;
   assign rsp_frame_status   = rsp_status_ff;
   assign rsp_payload_length = rsp_len_ff;

   `HFD_ASSERT(a_crc_idle_short, clock, reset, (cnt_ff < 16'd2) |-> (crc_ff == hfd_pkg::CRC_INIT), "CRC moved before two bytes were held")
   `HFD_ASSERT(a_ovf_frozen, clock, reset, (ovf_ff && pop && head.op == hfd_pkg::OP_DATA) |=> $stable(cnt_ff), "byte counted after overflow")
   `HFD_ASSERT(a_kind_onehot, clock, reset, rsp_valid_ff |-> (rsp_dv_ff != rsp_end_ff), "result is neither payload nor end, or both")
   `HFD_ASSERT(a_end_zero_byte, clock, reset, (rsp_valid_ff && rsp_end_ff) |-> (rsp_byte_ff == 8'h00), "end beat carries a byte")
   `HFD_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid_ff, "result valid right after reset")

endmodule

// ===== design/hdlc_frame_decoder.sv =====
// ---------------------------------------------------------------------------
// hdlc_frame_decoder
// HDLC-style byte deframer with unescape and CRC-16/X.25 frame check.
// ---------------------------------------------------------------------------
//   channel   ports                          beat
//   req       req_valid / req_stall          one raw received byte
//   rsp       rsp_valid / rsp_stall          one payload byte or one frame end
//   csr       csr_wr_en, csr_index, data     one register write
//
// One byte accepted per cycle unless req_stall is high; the back takes one
// queued beat a cycle unless rsp_stall holds its result. A byte is queued
// first; the back then pops it and registers any result it yields.
// While a result waits on rsp_stall the queue takes up to two more beats,
// then req_stall (the registered queue-full flag) rises.
// Synchronous reset restores register defaults and clears all frame state.
// ---------------------------------------------------------------------------
module hdlc_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_data_valid,
   output logic        rsp_frame_end,
   output logic [2:0]  rsp_frame_status,
   output logic [15:0] rsp_payload_length,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   hfd_pkg::cfg_type  cfg_ff, cfg_in;
   hfd_pkg::item_type push_item, head;
   logic              push, pop, q_valid, q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (hfd_pkg::reg_index_type'(csr_index))
            hfd_pkg::REG_FLAG:   cfg_in.flag_byte       = csr_wr_data[7:0];
            hfd_pkg::REG_ESCAPE: cfg_in.escape_byte     = csr_wr_data[7:0];
            hfd_pkg::REG_MASK:   cfg_in.escape_mask     = csr_wr_data[7:0];
            hfd_pkg::REG_MAX:    cfg_in.max_frame_bytes = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte       <= hfd_pkg::FLAG_RESET;
         cfg_ff.escape_byte     <= hfd_pkg::ESCAPE_RESET;
         cfg_ff.escape_mask     <= hfd_pkg::MASK_RESET;
         cfg_ff.max_frame_bytes <= hfd_pkg::MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;

   hfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .push        (push),
      .push_item   (push_item)
   );

   hfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_full    (q_full),
      .head      (head)
   );

   hfd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_valid            (q_valid),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_data_valid     (rsp_data_valid),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_payload_length (rsp_payload_length)
   );

endmodule
